### rtl/core/ssl_pkg.sv
// Shared constants and types for the servo slew limiter.
// The channel interfaces, the top level and its checker all use this package.
// No dependencies.
package ssl_pkg;

   // Queue geometry.
   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

   // Word field widths.
   localparam int OPCODE_W = 2;
   localparam int POS_W    = 8;
   localparam int DUTY_W   = 11;
   localparam int COUNT_W  = 4;
   localparam int STEP_W   = 8;

   // Configuration port widths and register indexes.
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE = 8'd1;

   // Operation codes.
   localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SET   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUEUE = 2'd2;

   // Position limit and duty scaling: duty = 1000 + pos * 1000 / 180.
   localparam logic [POS_W-1:0]  POS_LIMIT = 8'd180;
   localparam logic [DUTY_W-1:0] DUTY_BASE = 11'd1000;
   localparam logic [DUTY_W-1:0] DUTY_MAX  = 11'd2000;
   // pos * 1000 / 180 = pos * 50 / 9; divide by 9 with a reciprocal.
   localparam int SCALED_W  = 14;
   localparam int RECIP_W   = 16;
   localparam int DIV_SHIFT = 19;
   localparam int QUOT_W    = 10;
   localparam logic [RECIP_W-1:0] DIV9_RECIP = 16'd58255;

   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [FILL_W-1:0] fill_type;

endpackage

### rtl/core/ssl_if.sv
// Valid/ready channel interfaces for the servo slew limiter.
// Request, response and configuration write channels; depends on ssl_pkg.
interface ssl_req_if
   import ssl_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [POS_W-1:0]    position;

   modport source (output valid, output opcode, output position, input ready);
   modport sink   (input valid, input opcode, input position, output ready);
endinterface

interface ssl_rsp_if
   import ssl_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [DUTY_W-1:0]  pwm_duty;
   logic [POS_W-1:0]   current_position;
   logic               accepted;
   logic [COUNT_W-1:0] queue_count;

   modport source (output valid, output pwm_duty, output current_position,
                   output accepted, output queue_count, input ready);
   modport sink   (input valid, input pwm_duty, input current_position,
                   input accepted, input queue_count, output ready);
endinterface

interface ssl_csr_if
   import ssl_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/servo_slew_limiter_with_queue.sv
// A word accepted from the request channel is registered in the execute stage,
// then in the output register; a stalled response holds it in the execute stage.
// Throughput: one word per cycle unless the response side stalls; the queue head
// is prefetched from memory each cycle, so a pop never waits on the read port.
// Reset clears the position, goal, started flag, queue pointers and fill
// level and sets enable to 0 and step_size to 1. The queue memory is not
// cleared; an entry is read only after it has been written.
module servo_slew_limiter_with_queue
   import ssl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ssl_req_if.sink   req_chan,
   ssl_rsp_if.source rsp_chan,
   ssl_csr_if.sink   csr_chan
);

   // Configuration registers.
   logic              enable_ff, enable_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // Servo state.
   logic [POS_W-1:0] pos_now_ff, pos_now_in;
   logic [POS_W-1:0] goal_ff, goal_in;
   logic             started_ff, started_in;

   // Queue pointers, fill level, memory and prefetched head.
   ptr_type          wr_ptr_ff, wr_ptr_in;
   ptr_type          rd_ptr_ff, rd_ptr_in;
   fill_type         fill_ff, fill_in;
   logic [POS_W-1:0] fifo_mem [QUEUE_DEPTH];
   logic [POS_W-1:0] head_ff;
   logic             push;

   // Execute stage result register.
   logic               s1_valid_ff, s1_valid_in;
   logic [POS_W-1:0]   s1_pos_ff;
   logic               s1_started_ff;
   logic               s1_ok_ff;
   logic [COUNT_W-1:0] s1_count_ff;

   // Output register.
   logic               out_valid_ff, out_valid_in;
   logic [DUTY_W-1:0]  out_duty_ff;
   logic [POS_W-1:0]   out_pos_ff;
   logic               out_ok_ff;
   logic [COUNT_W-1:0] out_count_ff;

   logic req_fire, s1_move, ok;
   logic pos_valid, fifo_full, fifo_empty;
   logic [POS_W-1:0] goal_eff, move_diff;
   logic [POS_W:0]   move_sum;
   logic [SCALED_W-1:0]         scaled;
   logic [SCALED_W+RECIP_W-1:0] product;
   logic [QUOT_W-1:0]           quot;

   // Pipeline advance: the output register frees up or is taken this cycle.
   assign s1_move        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_move;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign pos_valid  = (req_chan.position <= POS_LIMIT);
   assign fifo_full  = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign fifo_empty = (fill_ff == '0);

   // Configuration writes; a zero step size is ignored.
   always_comb begin
      enable_in = enable_ff;
      step_in   = step_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            CSR_ENABLE: enable_in = csr_chan.data[0];
            CSR_STEP_SIZE: begin
               if (csr_chan.data != '0) begin
                  step_in = STEP_W'(csr_chan.data);
               end
            end
            default: ;
         endcase
      end
   end

   // Goal the tick moves toward: the queue head when the goal is reached.
   always_comb begin
      goal_eff = goal_ff;
      if (pos_now_ff == goal_ff && !fifo_empty) begin
         goal_eff = head_ff;
      end
   end

   assign move_sum  = {1'b0, pos_now_ff} + {1'b0, step_ff};
   assign move_diff = pos_now_ff - goal_eff;

   // Execute one word against the servo and queue state.
   always_comb begin
      pos_now_in = pos_now_ff;
      goal_in    = goal_ff;
      started_in = started_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      fill_in    = fill_ff;
      push       = 1'b0;
      ok         = 1'b0;
      if (req_fire) begin
         unique case (req_chan.opcode)
            OP_TICK: begin
               ok = 1'b1;
               if (enable_ff) begin
                  started_in = 1'b1;
                  goal_in    = goal_eff;
                  if (pos_now_ff == goal_ff && !fifo_empty) begin
                     rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ?
                                 '0 : rd_ptr_ff + PTR_W'(1);
                     fill_in   = fill_ff - FILL_W'(1);
                  end
                  // Move toward the goal, stopping at it from either side.
                  if (pos_now_ff < goal_eff) begin
                     pos_now_in = (move_sum > {1'b0, goal_eff}) ?
                                  goal_eff : move_sum[POS_W-1:0];
                  end else if (pos_now_ff > goal_eff) begin
                     pos_now_in = (move_diff <= step_ff) ?
                                  goal_eff : pos_now_ff - step_ff;
                  end
               end
            end
            OP_SET: begin
               if (pos_valid) begin
                  if (fifo_empty) begin
                     goal_in = req_chan.position;
                     ok      = 1'b1;
                  end else if (!fifo_full) begin
                     push = 1'b1;
                     ok   = 1'b1;
                  end
               end
            end
            OP_QUEUE: begin
               if (pos_valid && !fifo_full) begin
                  push = 1'b1;
                  ok   = 1'b1;
               end
            end
            default: ;
         endcase
         if (push) begin
            wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ?
                        '0 : wr_ptr_ff + PTR_W'(1);
            fill_in   = fill_ff + FILL_W'(1);
         end
      end
   end

   // Queue memory with the head prefetched at the next read pointer.
   // A write to that same entry in this cycle is forwarded into the head.
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= req_chan.position;
      end
      if (push && wr_ptr_ff == rd_ptr_in) begin
         head_ff <= req_chan.position;
      end else begin
         head_ff <= fifo_mem[rd_ptr_in];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         step_ff    <= STEP_W'(1);
         pos_now_ff <= '0;
         goal_ff    <= '0;
         started_ff <= 1'b0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         fill_ff    <= '0;
      end else begin
         enable_ff  <= enable_in;
         step_ff    <= step_in;
         pos_now_ff <= pos_now_in;
         goal_ff    <= goal_in;
         started_ff <= started_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         fill_ff    <= fill_in;
      end
   end

   // Stage valid flags.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Execute stage payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pos_ff     <= pos_now_in;
         s1_started_ff <= started_in;
         s1_ok_ff      <= ok;
         s1_count_ff   <= COUNT_W'(fill_in);
      end
   end

   // Duty scaling: pos * 50, then divide by 9 with a reciprocal multiply.
   assign scaled  = (SCALED_W'(s1_pos_ff) << 5) + (SCALED_W'(s1_pos_ff) << 4)
                    + (SCALED_W'(s1_pos_ff) << 1);
   assign product = (SCALED_W + RECIP_W)'(scaled) * (SCALED_W + RECIP_W)'(DIV9_RECIP);
   assign quot    = product[DIV_SHIFT +: QUOT_W];

   // Output register.
   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_duty_ff  <= s1_started_ff ? DUTY_BASE + DUTY_W'(quot) : '0;
         out_pos_ff   <= s1_pos_ff;
         out_ok_ff    <= s1_ok_ff;
         out_count_ff <= s1_count_ff;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.pwm_duty         = out_duty_ff;
   assign rsp_chan.current_position = out_pos_ff;
   assign rsp_chan.accepted         = out_ok_ff;
   assign rsp_chan.queue_count      = out_count_ff;

endmodule

### rtl/core/ssl_checker.sv
// Port-level checks for the servo slew limiter, bound to the top level.
// Depends on ssl_pkg and servo_slew_limiter_with_queue.
module ssl_checker
   import ssl_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [DUTY_W-1:0]  rsp_duty,
   input logic [POS_W-1:0]   rsp_pos,
   input logic [COUNT_W-1:0] rsp_count
);

   // A stalled response word keeps its position and duty.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos) && $stable(rsp_duty))
      else $error("response word changed while stalled");

   // The position never leaves the legal range.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pos <= POS_LIMIT)
      else $error("position above limit");

   // Once running, the duty lies in its servo range.
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_duty != '0 |-> rsp_duty >= DUTY_BASE && rsp_duty <= DUTY_MAX)
      else $error("duty out of range");

   // Before the first enabled tick the position cannot have moved.
   a_idle_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_duty == '0 |-> rsp_pos == '0)
      else $error("position moved without a duty");

   // The queue never holds more than its depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= COUNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

endmodule

bind servo_slew_limiter_with_queue ssl_checker u_ssl_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_duty  (rsp_chan.pwm_duty),
   .rsp_pos   (rsp_chan.current_position),
   .rsp_count (rsp_chan.queue_count)
);

### tb/ssl_response_check.sv
`timescale 1ns / 100ps
// Response checker for the servo slew limiter: watches the request, response and
// configuration channels, predicts each response word and compares it field by field.
// Depends on ssl_pkg and the channel interfaces in ssl_if.sv.
module ssl_response_check
   import ssl_pkg::*;
(
   input  logic clock,
   input  logic reset,
   ssl_req_if   req_mon,
   ssl_rsp_if   rsp_mon,
   ssl_csr_if   csr_mon,
   output int   fail_count,
   output int   words_in_flight
);

   localparam int DUTY_SPAN   = 1000;
   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      logic [DUTY_W-1:0]  pwm_duty;
      logic [POS_W-1:0]   current_position;
      logic               accepted;
      logic [COUNT_W-1:0] queue_count;
   } servo_word_type;

   // Mirror of the servo state and its two registers.
   logic              power_on;
   logic [STEP_W-1:0] slew_step;
   logic [POS_W-1:0]  servo_pos;
   logic [POS_W-1:0]  goal_pos;
   logic [DUTY_W-1:0] duty_us;
   logic [POS_W-1:0]  goal_queue[$];

   servo_word_type predicted_words[$];

   initial begin
      fail_count      = 0;
      words_in_flight = 0;
   end

   task automatic report_mismatch(string msg);
      if (fail_count < PRINT_LIMIT)
         $display("%0t ns: mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic check_field(string field, int got, int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d, expected %0d", field, got, want));
   endtask

   // Moves the mirrored servo by one word and returns the response it should give.
   function automatic servo_word_type advance_servo(logic [OPCODE_W-1:0] op,
                                                    logic [POS_W-1:0] pos);
      servo_word_type word;
      logic           ok;
      logic [POS_W:0] stepped;
      int             scaled;
      ok = 1'b0;
      case (op)
         OP_TICK: begin
            ok = 1'b1;
            if (power_on) begin
               // A settled servo takes its next goal from the queue first.
               if (servo_pos == goal_pos && goal_queue.size() > 0)
                  goal_pos = goal_queue.pop_front();
               // Slew toward the goal and stop on it in either direction.
               if (servo_pos < goal_pos) begin
                  stepped   = {1'b0, servo_pos} + {1'b0, slew_step};
                  servo_pos = (stepped > {1'b0, goal_pos}) ? goal_pos : stepped[POS_W-1:0];
               end else if (servo_pos > goal_pos) begin
                  if (servo_pos - goal_pos <= slew_step)
                     servo_pos = goal_pos;
                  else
                     servo_pos = servo_pos - slew_step;
               end
               scaled  = int'(DUTY_BASE) + (int'(servo_pos) * DUTY_SPAN) / int'(POS_LIMIT);
               duty_us = scaled[DUTY_W-1:0];
            end
         end
         OP_SET: begin
            if (pos <= POS_LIMIT) begin
               if (goal_queue.size() == 0) begin
                  goal_pos = pos;
                  ok       = 1'b1;
               end else if (goal_queue.size() < QUEUE_DEPTH) begin
                  goal_queue.push_back(pos);
                  ok = 1'b1;
               end
            end
         end
         OP_QUEUE: begin
            if (pos <= POS_LIMIT && goal_queue.size() < QUEUE_DEPTH) begin
               goal_queue.push_back(pos);
               ok = 1'b1;
            end
         end
         default: ;
      endcase
      word.pwm_duty         = duty_us;
      word.current_position = servo_pos;
      word.accepted         = ok;
      word.queue_count      = COUNT_W'(goal_queue.size());
      return word;
   endfunction

   // Sample all three channels at the clock edge and keep the mirror in step.
   always @(posedge clock) begin
      servo_word_type want;
      if (reset) begin
         power_on  = 1'b0;
         slew_step = STEP_W'(1);
         servo_pos = '0;
         goal_pos  = '0;
         duty_us   = '0;
         goal_queue.delete();
         predicted_words.delete();
      end else begin
         // Register writes: only bit 0 of enable counts, a zero step is dropped.
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == CSR_ENABLE)
               power_on = csr_mon.data[0];
            else if (csr_mon.index == CSR_STEP_SIZE && csr_mon.data != '0)
               slew_step = csr_mon.data;
         end
         if (req_mon.valid && req_mon.ready)
            predicted_words.push_back(advance_servo(req_mon.opcode, req_mon.position));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_words.size() == 0) begin
               report_mismatch("response word with no request waiting");
            end else begin
               want = predicted_words.pop_front();
               check_field("pwm_duty", rsp_mon.pwm_duty, want.pwm_duty);
               check_field("current_position", rsp_mon.current_position,
                           want.current_position);
               check_field("accepted", rsp_mon.accepted, want.accepted);
               check_field("queue_count", rsp_mon.queue_count, want.queue_count);
            end
         end
      end
      words_in_flight <= predicted_words.size();
   end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Top of the servo slew limiter testbench: clock, reset, stimulus and verdict.
// Depends on ssl_pkg, ssl_if.sv, the block itself and ssl_response_check.
module tb
   import ssl_pkg::*;
();

   localparam logic [OPCODE_W-1:0]  OP_UNUSED        = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_INDEX   = 8'hFF;
   localparam int RANDOM_PHASES = 16;
   localparam int PHASE_WORDS   = 100;
   localparam int HOLD_CYCLES   = 250;
   localparam int SETTLE_CYCLES = 6;
   localparam int DRAIN_LIMIT   = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   holds_asked = 0;
   int   holds_done  = 0;
   bit   req_quiet = 1'b0;
   bit   rsp_quiet = 1'b0;
   int   failures;
   int   in_flight;

   ssl_req_if req_chan ();
   ssl_rsp_if rsp_chan ();
   ssl_csr_if csr_chan ();

   servo_slew_limiter_with_queue dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   ssl_response_check check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_mon         (csr_chan),
      .fail_count      (failures),
      .words_in_flight (in_flight)
   );

   always #1 clock = ~clock;

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap(bit quiet);
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one request word, wait for its handshake, then maybe pause.
   // Valid stays high when the next word follows without a gap.
   task automatic send_word(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos);
      int gap;
      req_chan.valid    <= 1'b1;
      req_chan.opcode   <= op;
      req_chan.position <= pos;
      do @(posedge clock); while (!req_chan.ready);
      gap = pick_gap(req_quiet);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stop offering words and wait until every predicted word has come back.
   task automatic wait_idle();
      int waited;
      waited = 0;
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Response side: random stalls, plus one long hold-off each time one is asked for.
   initial begin : receiver
      int gap;
      rsp_chan.ready <= 1'b0;
      forever begin
         if (holds_asked != holds_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done     <= holds_done + 1;
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end else begin
            gap = pick_gap(rsp_quiet);
            if (gap == 0) begin
               rsp_chan.ready <= 1'b1;
               @(posedge clock);
            end else begin
               rsp_chan.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // Request and configuration stimulus, then the verdict.
   initial begin : stimulus
      int r;
      int q;
      logic [OPCODE_W-1:0] op;
      logic [POS_W-1:0]    pos;
      logic [STEP_W-1:0]   step;
      req_chan.valid    <= 1'b0;
      req_chan.opcode   <= OP_TICK;
      req_chan.position <= '0;
      csr_chan.valid    <= 1'b0;
      csr_chan.index    <= CSR_ENABLE;
      csr_chan.data     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Powered off: a tick leaves the duty at zero, bad positions and the
      // unused opcode are refused, and a set goes straight to the goal.
      send_word(OP_TICK, 8'd0);
      send_word(OP_SET, 8'd181);
      send_word(OP_SET, 8'd255);
      send_word(OP_SET, POS_LIMIT);
      send_word(OP_UNUSED, 8'd0);
      send_word(OP_QUEUE, 8'd200);
      send_word(OP_QUEUE, 8'd7);
      wait_idle();

      // Enable with bit 0 clear, a zero step and unknown indexes change nothing.
      write_reg(CSR_ENABLE, 8'hFE);
      write_reg(CSR_STEP_SIZE, 8'd0);
      write_reg(CSR_FIRST_UNUSED, 8'hFF);
      write_reg(CSR_LAST_INDEX, 8'h55);
      send_word(OP_TICK, 8'hFF);
      wait_idle();

      // Powered on with the reset step of one.
      write_reg(CSR_ENABLE, 8'h01);
      send_word(OP_TICK, 8'd0);
      wait_idle();

      // Largest step: the move stops on the goal going up and coming down,
      // then the queue fills up and refuses both command kinds.
      write_reg(CSR_STEP_SIZE, 8'd255);
      send_word(OP_TICK, 8'd0);
      send_word(OP_TICK, 8'd0);
      send_word(OP_QUEUE, 8'd0);
      send_word(OP_QUEUE, POS_LIMIT);
      for (int i = 0; i < 7; i++)
         send_word(OP_QUEUE, POS_W'(i * 25 + 5));
      send_word(OP_SET, 8'd45);
      repeat (4) send_word(OP_TICK, 8'd0);
      wait_idle();

      // Random phases, each under a fresh register setting.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         q = $urandom_range(0, 9);
         case (q)
            0:       step = 8'd0;
            1:       step = 8'd1;
            2:       step = 8'd255;
            3, 4, 5, 6: step = STEP_W'($urandom_range(1, 12));
            default: step = STEP_W'($urandom_range(1, 255));
         endcase
         write_reg(CSR_STEP_SIZE, step);
         write_reg(CSR_ENABLE, {7'($urandom_range(0, 127)), ($urandom_range(0, 4) != 0)});
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_IDX_W'($urandom_range(CSR_FIRST_UNUSED, CSR_LAST_INDEX)),
                      CSR_DATA_W'($urandom));
         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         if (phase == 3 || phase == 10) begin
            req_quiet = 1'b1;
            holds_asked <= holds_asked + 1;
         end

         // Mostly ticks and queue traffic with valid positions, some refusals.
         for (int n = 0; n < PHASE_WORDS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
               op = OP_TICK;
            else if (r < 65)
               op = OP_SET;
            else if (r < 92)
               op = OP_QUEUE;
            else
               op = OP_UNUSED;
            q = $urandom_range(0, 19);
            case (q)
               0:       pos = 8'd0;
               1:       pos = POS_LIMIT;
               2:       pos = POS_W'($urandom_range(181, 255));
               3:       pos = 8'd255;
               default: pos = POS_W'($urandom_range(0, 180));
            endcase
            send_word(op, pos);
         end
         wait_idle();
      end

      if (failures == 0 && in_flight == 0)
         $display("servo_slew_limiter_with_queue regression: pass");
      else
         $display("servo_slew_limiter_with_queue regression: fail");
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin : watchdog
      #2000000;
      $display("servo_slew_limiter_with_queue regression: fail");
      $finish;
   end

endmodule

### files.f
rtl/core/ssl_pkg.sv
rtl/core/ssl_if.sv
rtl/core/servo_slew_limiter_with_queue.sv
rtl/core/ssl_checker.sv
tb/ssl_response_check.sv
tb/tb.sv
